/* src/nggp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nggp_pkg
// Shared types and constants of the GGA/VTG sentence parser.
// ----------------------------------------------------------------------------
package nggp_pkg;

    localparam int LINE_MAX = 64;
    localparam int LINE_W   = $clog2(LINE_MAX + 1);

    localparam logic [39:0] TAG_GGA = 40'h4750474741;
    localparam logic [39:0] TAG_VTG = 40'h4750565447;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_VTG  = 2'd2
    } t_kind;

    localparam logic [2:0] SLOT_LAT = 3'd0;
    localparam logic [2:0] SLOT_LON = 3'd1;
    localparam logic [2:0] SLOT_ACC = 3'd2;
    localparam logic [2:0] SLOT_ALT = 3'd3;
    localparam logic [2:0] SLOT_CRS = 3'd4;
    localparam logic [2:0] SLOT_SPD = 3'd5;
    localparam logic [2:0] SLOT_NS  = 3'd6;
    localparam logic [2:0] SLOT_EW  = 3'd7;

    localparam logic [1:0] HEMI_NONE = 2'd0;
    localparam logic [1:0] HEMI_POS  = 2'd1;
    localparam logic [1:0] HEMI_NEG  = 2'd2;

    typedef struct packed {
        logic        has_close;
        logic [2:0]  slot;
        logic [31:0] num_a;
        logic [31:0] num_b;
        logic [3:0]  dec;
        logic        short_fld;
        logic        deg_zero;
        logic [1:0]  hemi;
        logic        has_eol;
        t_kind       apply;
    } t_evt;

    typedef struct packed {
        t_kind              kind;
        logic signed [30:0] lat;
        logic signed [30:0] lon;
        logic [31:0]        acc;
        logic [31:0]        alt;
        logic signed [31:0] course;
        logic [26:0]        speed;
    } t_res;

endpackage
`default_nettype wire

/* src/nggp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nggp_front
// Byte-level tokenizer: tag detection, comma counting, digit accumulation.
// ----------------------------------------------------------------------------
module nggp_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire [7:0]            i_rx_byte,
    input  wire                  i_end_of_line,
    output logic                 o_evt_valid,
    output nggp_pkg::t_evt       o_evt
);

    logic [39:0]                 r_win, n_win;
    nggp_pkg::t_kind             r_kind, n_kind;
    logic [3:0]                  r_cc, n_cc;
    logic [7:0]                  r_flen, n_flen;
    logic [nggp_pkg::LINE_W-1:0] r_llen, n_llen;
    logic [31:0]                 r_acc, n_acc;
    logic [31:0]                 r_dw, n_dw;
    logic [31:0]                 r_d5, n_d5;
    logic [31:0]                 r_mf, n_mf;
    logic [31:0]                 r_ml, n_ml;
    logic [3:0]                  r_dec, n_dec;
    logic                        r_pt, n_pt;
    logic [7:0]                  r_first, n_first;

    logic        take;
    logic [31:0] dig;
    logic [3:0]  fk;
    logic        close_ev;
    logic [2:0]  slot;
    logic [7:0]  ch_pos;
    logic [7:0]  ch_neg;

    always_comb begin
        take = r_llen < nggp_pkg::LINE_W'(nggp_pkg::LINE_MAX);
        dig  = {24'd0, i_rx_byte} - {24'd0, nggp_pkg::CH_ZERO};
        fk   = r_cc - 4'd1;

        n_win = r_win; n_kind = r_kind; n_cc = r_cc; n_flen = r_flen;
        n_llen = r_llen; n_acc = r_acc; n_dw = r_dw; n_d5 = r_d5;
        n_mf = r_mf; n_ml = r_ml; n_dec = r_dec; n_pt = r_pt; n_first = r_first;

        close_ev = 1'b0;
        slot     = nggp_pkg::SLOT_LAT;
        if (r_kind == nggp_pkg::KIND_GGA) begin
            case (fk)
                4'd1:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_LAT; end
                4'd2:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_NS;  end
                4'd3:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_LON; end
                4'd4:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_EW;  end
                4'd7:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_ACC; end
                4'd8:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_ALT; end
                default: close_ev = 1'b0;
            endcase
        end else if (r_kind == nggp_pkg::KIND_VTG) begin
            case (fk)
                4'd0:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_CRS; end
                4'd6:    begin close_ev = 1'b1; slot = nggp_pkg::SLOT_SPD; end
                default: close_ev = 1'b0;
            endcase
        end
        if (!(take && r_kind != nggp_pkg::KIND_NONE && i_rx_byte == nggp_pkg::CH_COMMA
              && r_cc != 4'd0)) begin
            close_ev = 1'b0;
        end

        ch_pos = (slot == nggp_pkg::SLOT_NS) ? nggp_pkg::CH_N : nggp_pkg::CH_E;
        ch_neg = (slot == nggp_pkg::SLOT_NS) ? nggp_pkg::CH_S : nggp_pkg::CH_W;

        o_evt.has_close = close_ev;
        o_evt.slot      = slot;
        o_evt.num_a     = (slot == nggp_pkg::SLOT_LAT || slot == nggp_pkg::SLOT_LON)
                          ? ((r_flen == 8'd9) ? r_dw : r_d5) : r_acc;
        o_evt.num_b     = (r_flen == 8'd9) ? r_mf : r_ml;
        o_evt.dec       = r_pt ? r_dec : 4'd0;
        o_evt.short_fld = r_flen < 8'd2;
        o_evt.deg_zero  = (r_flen != 8'd9) && (r_flen != 8'd10);
        o_evt.hemi      = nggp_pkg::HEMI_NONE;
        if (r_flen == 8'd1) begin
            if (r_first == ch_pos) begin
                o_evt.hemi = nggp_pkg::HEMI_POS;
            end else if (r_first == ch_neg) begin
                o_evt.hemi = nggp_pkg::HEMI_NEG;
            end
        end

        if (take) begin
            n_llen = r_llen + nggp_pkg::LINE_W'(1);
            if (r_kind == nggp_pkg::KIND_NONE) begin
                n_win = {r_win[31:0], i_rx_byte};
                if (r_llen >= nggp_pkg::LINE_W'(4)) begin
                    if (n_win == nggp_pkg::TAG_GGA) begin
                        n_kind = nggp_pkg::KIND_GGA;
                    end else if (n_win == nggp_pkg::TAG_VTG) begin
                        n_kind = nggp_pkg::KIND_VTG;
                    end
                end
            end else if (i_rx_byte == nggp_pkg::CH_COMMA) begin
                if (r_cc != 4'hF) begin
                    n_cc = r_cc + 4'd1;
                end
                n_flen = '0; n_acc = '0; n_dw = '0; n_d5 = '0; n_mf = '0;
                n_ml = '0; n_dec = '0; n_pt = 1'b0; n_first = '0;
            end else if (r_cc != 4'd0) begin
                if (r_flen == 8'd0) begin
                    n_first = i_rx_byte;
                end
                if (i_rx_byte == nggp_pkg::CH_POINT) begin
                    n_pt  = 1'b1;
                    n_dec = 4'd0;
                end else begin
                    n_acc = r_acc * 32'd10 + dig;
                    if (r_pt && r_dec != 4'hF) begin
                        n_dec = r_dec + 4'd1;
                    end
                end
                if (r_flen < 8'd4) begin
                    n_dw = r_dw * 32'd10 + dig;
                end
                if (r_flen == 8'd4) begin
                    n_d5 = r_dw * 32'd10 + dig;
                end
                if (r_flen >= 8'd5 && r_flen <= 8'd8) begin
                    n_mf = r_mf * 32'd10 + dig;
                end
                if (r_flen >= 8'd6 && r_flen <= 8'd9) begin
                    n_ml = r_ml * 32'd10 + dig;
                end
                if (r_flen != 8'hFF) begin
                    n_flen = r_flen + 8'd1;
                end
            end
        end

        o_evt.has_eol = i_end_of_line;
        o_evt.apply   = nggp_pkg::KIND_NONE;
        if (n_kind == nggp_pkg::KIND_GGA && n_cc >= 4'd14) begin
            o_evt.apply = nggp_pkg::KIND_GGA;
        end else if (n_kind == nggp_pkg::KIND_VTG && n_cc >= 4'd9) begin
            o_evt.apply = nggp_pkg::KIND_VTG;
        end

        if (i_end_of_line) begin
            n_win = '0; n_kind = nggp_pkg::KIND_NONE; n_cc = '0; n_llen = '0;
            n_flen = '0; n_acc = '0; n_dw = '0; n_d5 = '0; n_mf = '0;
            n_ml = '0; n_dec = '0; n_pt = 1'b0; n_first = '0;
        end

        o_evt_valid = i_accept && (close_ev || i_end_of_line);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0; r_kind <= nggp_pkg::KIND_NONE; r_cc <= '0; r_flen <= '0;
            r_llen <= '0; r_acc <= '0; r_dw <= '0; r_d5 <= '0; r_mf <= '0;
            r_ml <= '0; r_dec <= '0; r_pt <= 1'b0; r_first <= '0;
        end else if (i_accept) begin
            r_win <= n_win; r_kind <= n_kind; r_cc <= n_cc; r_flen <= n_flen;
            r_llen <= n_llen; r_acc <= n_acc; r_dw <= n_dw; r_d5 <= n_d5;
            r_mf <= n_mf; r_ml <= n_ml; r_dec <= n_dec; r_pt <= n_pt;
            r_first <= n_first;
        end
    end

endmodule
`default_nettype wire

/* src/nggp_evq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nggp_evq
// Small request queue between the tokenizer and the conversion unit.
// ----------------------------------------------------------------------------
module nggp_evq (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  nggp_pkg::t_evt   i_evt,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output nggp_pkg::t_evt   o_evt
);

    nggp_pkg::t_evt                 r_mem [nggp_pkg::EVQ_DEPTH];
    logic [nggp_pkg::EVQ_AW-1:0]    r_wp, r_rp;
    logic [nggp_pkg::EVQ_AW:0]      r_cnt;
    logic                           do_push, do_pop;

    assign o_full  = r_cnt == (nggp_pkg::EVQ_AW + 1)'(nggp_pkg::EVQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_evt   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + nggp_pkg::EVQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + nggp_pkg::EVQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (nggp_pkg::EVQ_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (nggp_pkg::EVQ_AW + 1)'(1);
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (nggp_pkg::EVQ_AW + 1)'(nggp_pkg::EVQ_DEPTH))
        else $error("event queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("request pushed into full event queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("request popped from empty event queue");
`endif

endmodule
`default_nettype wire

/* src/nggp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nggp_back
// Conversion sequencer: degree/number scaling, pending and stored values,
// result queue.
// ----------------------------------------------------------------------------
module nggp_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_evt_valid,
    input  nggp_pkg::t_evt   i_evt,
    output logic             o_evt_pop,
    input  wire              i_pop,
    output logic             o_empty,
    output nggp_pkg::t_res   o_res
);

    localparam logic [31:0] MOD_BASE = 32'd1000000;
    localparam logic [21:0] DIV3_MUL = 22'd1398102;
    localparam logic [31:0] DIV10_MUL = 32'hCCCCCCCD;
    localparam logic [29:0] DIV9_MUL = 30'd954437177;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_DMUL, S_DMOD, S_DDIV, S_DADD,
        S_NSCL, S_SMUL, S_SDIV, S_WRAP, S_EOL
    } t_state;

    t_state          r_state;
    nggp_pkg::t_evt  r_evt;
    logic [31:0]     r_val, r_res;
    logic [3:0]      r_dec, r_cnt;
    logic            r_post;
    logic [31:0]     r_pend [6];
    logic [1:0]      r_sgn [2];
    logic [31:0]     r_sto [6];
    nggp_pkg::t_res  r_oq [2];
    logic            r_owp, r_orp;
    logic [1:0]      r_ocnt;

    logic [31:0]     mul10, div10, modk, div3, wrapv, spdq, degm;
    logic [63:0]     prod10;
    logic [42:0]     prod3;
    logic [59:0]     prod9;
    logic            pend_we;
    logic [31:0]     pend_data;
    logic [31:0]     n_sto [6];
    nggp_pkg::t_res  res_new;
    t_state          fin_state;
    logic            out_push, out_pop;

    function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic [1:0] code);
        logic [31:0] r;
        case (code)
            nggp_pkg::HEMI_POS: r = mag;
            nggp_pkg::HEMI_NEG: r = 32'd0 - mag;
            default:            r = 32'd0;
        endcase
        return r;
    endfunction

    always_comb begin
        mul10  = r_val * 32'd10;
        prod10 = {32'd0, r_val} * {32'd0, DIV10_MUL};
        div10  = {3'd0, prod10[63:35]};
        modk   = MOD_BASE << r_cnt;
        prod3  = {21'd0, r_val[20:0], 1'b0} * {21'd0, DIV3_MUL};
        div3   = {12'd0, prod3[41:22]};
        wrapv  = (r_val > 32'd180) ? r_val - 32'd360 : r_val;
        prod9  = {30'd0, r_val[31:2]} * {30'd0, DIV9_MUL};
        spdq   = {5'd0, prod9[59:33]};
        degm   = r_evt.num_a * 32'd10000 + r_evt.num_b;
        fin_state = r_evt.has_eol ? S_EOL : S_IDLE;

        pend_we   = 1'b0;
        pend_data = r_val;
        case (r_state)
            S_DISP: begin
                if ((r_evt.slot == nggp_pkg::SLOT_LAT || r_evt.slot == nggp_pkg::SLOT_LON)
                    && r_evt.has_close && r_evt.deg_zero) begin
                    pend_we   = 1'b1;
                    pend_data = 32'd0;
                end
            end
            S_NSCL: begin
                pend_we = (r_dec == 4'd2) &&
                          (r_evt.slot == nggp_pkg::SLOT_ACC || r_evt.slot == nggp_pkg::SLOT_ALT);
            end
            S_DADD: begin
                pend_we   = 1'b1;
                pend_data = r_res + r_val;
            end
            S_WRAP: begin
                pend_we   = 1'b1;
                pend_data = wrapv;
            end
            S_SDIV: begin
                pend_we   = 1'b1;
                pend_data = spdq;
            end
            default: pend_we = 1'b0;
        endcase

        for (int i = 0; i < 6; i++) begin
            n_sto[i] = r_sto[i];
        end
        if (r_evt.apply == nggp_pkg::KIND_GGA) begin
            n_sto[0] = apply_sign(r_pend[0], r_sgn[0]);
            n_sto[1] = apply_sign(r_pend[1], r_sgn[1]);
            n_sto[2] = r_pend[2];
            n_sto[3] = r_pend[3];
        end else if (r_evt.apply == nggp_pkg::KIND_VTG) begin
            n_sto[4] = r_pend[4];
            n_sto[5] = r_pend[5];
        end
        res_new.kind   = r_evt.apply;
        res_new.lat    = n_sto[0][30:0];
        res_new.lon    = n_sto[1][30:0];
        res_new.acc    = n_sto[2];
        res_new.alt    = n_sto[3];
        res_new.course = n_sto[4];
        res_new.speed  = n_sto[5][26:0];

        out_push  = (r_state == S_EOL) && (r_ocnt != 2'd2);
        out_pop   = i_pop && (r_ocnt != 2'd0);
        o_empty   = r_ocnt == 2'd0;
        o_res     = r_oq[r_orp];
        o_evt_pop = (r_state == S_IDLE) && i_evt_valid;
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend[r_evt.slot] <= pend_data;
        end
        if (out_push) begin
            r_oq[r_owp] <= res_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_evt   <= '0;
            r_val   <= '0;
            r_res   <= '0;
            r_dec   <= '0;
            r_cnt   <= '0;
            r_post  <= 1'b0;
            r_sgn[0] <= '0;
            r_sgn[1] <= '0;
            for (int i = 0; i < 6; i++) begin
                r_sto[i] <= '0;
            end
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_evt_valid) begin
                        r_evt   <= i_evt;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (!r_evt.has_close) begin
                        r_state <= S_EOL;
                    end else begin
                        case (r_evt.slot)
                            nggp_pkg::SLOT_LAT, nggp_pkg::SLOT_LON: begin
                                r_state <= r_evt.deg_zero ? fin_state : S_DMUL;
                            end
                            nggp_pkg::SLOT_NS: begin
                                r_sgn[0] <= r_evt.hemi;
                                r_state  <= fin_state;
                            end
                            nggp_pkg::SLOT_EW: begin
                                r_sgn[1] <= r_evt.hemi;
                                r_state  <= fin_state;
                            end
                            default: begin
                                r_val   <= r_evt.short_fld ? 32'hFFFFFFFF : r_evt.num_a;
                                r_dec   <= r_evt.short_fld ? 4'd2 : r_evt.dec;
                                r_post  <= 1'b0;
                                r_state <= S_NSCL;
                            end
                        endcase
                    end
                end
                S_DMUL: begin
                    r_res   <= degm;
                    r_val   <= degm;
                    r_cnt   <= 4'd12;
                    r_state <= S_DMOD;
                end
                S_DMOD: begin
                    if (r_val >= modk) begin
                        r_val <= r_val - modk;
                    end
                    if (r_cnt == 4'd0) begin
                        r_state <= S_DDIV;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                S_DDIV: begin
                    r_val   <= div3;
                    r_state <= S_DADD;
                end
                S_DADD: begin
                    r_state <= fin_state;
                end
                S_NSCL: begin
                    if (r_dec < 4'd2) begin
                        r_val <= mul10;
                        r_dec <= r_dec + 4'd1;
                    end else if (r_dec > 4'd2) begin
                        r_val <= div10;
                        r_dec <= r_dec - 4'd1;
                    end else begin
                        case (r_evt.slot)
                            nggp_pkg::SLOT_CRS: begin
                                if (!r_post) begin
                                    r_post <= 1'b1;
                                    r_dec  <= 4'd4;
                                end else begin
                                    r_state <= S_WRAP;
                                end
                            end
                            nggp_pkg::SLOT_SPD: r_state <= S_SMUL;
                            default:            r_state <= fin_state;
                        endcase
                    end
                end
                S_SMUL: begin
                    r_val   <= r_val * 32'd100;
                    r_state <= S_SDIV;
                end
                S_SDIV: begin
                    r_state <= fin_state;
                end
                S_WRAP: begin
                    r_state <= fin_state;
                end
                S_EOL: begin
                    if (out_push) begin
                        for (int i = 0; i < 6; i++) begin
                            r_sto[i] <= n_sto[i];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_push) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            if (out_push && !out_pop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (out_pop && !out_push) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

`ifndef SYNTH
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result queue count out of range");
    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_evt_pop)
        else $error("request taken while sequencer busy");
    a_dmod_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DMOD) |-> (r_cnt <= 4'd12))
        else $error("remainder step count out of range");
`endif

endmodule
`default_nettype wire

/* src/nmea_gga_vtg_sentence_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_gga_vtg_sentence_parser_unit
// Parses GGA/VTG text lines byte by byte into fixed-point position data.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue write port: a byte is taken on a clock edge with
//   i_push high and o_full low; i_end_of_line marks the last byte of a line.
//   Results form a queue read port: while o_empty is low the oldest result
//   is on the o_* fields and i_pop takes it. One result per line end.
// Throughput: one byte per cycle while o_full is low. The tokenizer writes a request into a
//   four-entry queue for each relevant field close and each line end.
// Conversion: the sequencer handles a sign, a line end, a number field
//   (one decimal rescale per cycle; course and speed add further
//   scaling steps) and a degree field (13-step remainder). A line end
//   passes the request queue and the sequencer's dispatch and line-end
//   states before its result is queued. o_full rises only when requests
//   arrive faster than the sequencer takes them.
// Reset: synchronous, clears line state, signs and stored values; both
//   queues empty. A stalled reader fills the two-entry result queue, then
//   the request queue, and then o_full holds off input.
// ----------------------------------------------------------------------------
module nmea_gga_vtg_sentence_parser_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  wire [7:0]          i_rx_byte,
    input  wire                i_end_of_line,
    input  wire                i_pop,
    output logic               o_empty,
    output logic [1:0]         o_sentence_kind,
    output logic signed [30:0] o_latitude_udeg,
    output logic signed [30:0] o_longitude_udeg,
    output logic [31:0]        o_fix_accuracy,
    output logic [31:0]        o_altitude_cm,
    output logic signed [31:0] o_course_deg,
    output logic [26:0]        o_speed_value
);

    logic            accept;
    logic            fe_valid;
    nggp_pkg::t_evt  fe_evt;
    logic            q_valid;
    logic            q_pop;
    nggp_pkg::t_evt  q_evt;
    nggp_pkg::t_res  res;

    assign accept = i_push && !o_full;

    nggp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_end_of_line (i_end_of_line),
        .o_evt_valid   (fe_valid),
        .o_evt         (fe_evt)
    );

    nggp_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_evt   (fe_evt),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_evt   (q_evt)
    );

    nggp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (q_valid),
        .i_evt       (q_evt),
        .o_evt_pop   (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (res)
    );

    assign o_sentence_kind  = res.kind;
    assign o_latitude_udeg  = res.lat;
    assign o_longitude_udeg = res.lon;
    assign o_fix_accuracy   = res.acc;
    assign o_altitude_cm    = res.alt;
    assign o_course_deg     = res.course;
    assign o_speed_value    = res.speed;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the GGA/VTG sentence parser: sends GPS text lines byte by byte with
// random send gaps and read stalls, and compares each line-end result with a
// bit-exact behavioral parser kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_top;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_push;
    logic              o_full;
    logic [7:0]        i_rx_byte;
    logic              i_end_of_line;
    logic              i_pop;
    logic              o_empty;
    logic [1:0]        o_sentence_kind;
    logic signed [30:0] o_latitude_udeg;
    logic signed [30:0] o_longitude_udeg;
    logic [31:0]       o_fix_accuracy;
    logic [31:0]       o_altitude_cm;
    logic signed [31:0] o_course_deg;
    logic [26:0]       o_speed_value;

    nmea_gga_vtg_sentence_parser_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // parser state
    logic [39:0]       win;
    nggp_pkg::t_kind   lkind;
    logic [31:0] commas, flen, llen, acc, dwhole, dfive, mfrac, mlate, decs;
    logic        pnt;
    logic [7:0]  fbyte;
    logic [31:0] pend [6];
    logic [1:0]  psign [2];
    logic [31:0] stored [6];

    nggp_pkg::t_res results_q[$];
    int          errors = 0;
    int          bytes_sent = 0;
    longint      cycles = 0;
    int          send_burst = 0;

    task automatic clear_field();
        flen = 0; acc = 0; dwhole = 0; dfive = 0; mfrac = 0; mlate = 0;
        decs = 0; pnt = 1'b0; fbyte = 8'd0;
    endtask

    task automatic clear_line();
        win = 40'd0; lkind = nggp_pkg::KIND_NONE; commas = 0; llen = 0;
        clear_field();
    endtask

    function automatic logic [31:0] num_val();
        logic [31:0] r;
        logic [31:0] d;
        r = acc;
        d = pnt ? decs : 0;
        if (flen < 2) return 32'hFFFF_FFFF;
        while (d < 2) begin r = r * 10; d++; end
        while (d > 2) begin r = r / 10; d--; end
        return r;
    endfunction

    function automatic logic [31:0] deg_val();
        logic [31:0] r;
        if (flen == 9) r = dwhole * 10000 + mfrac;
        else if (flen == 10) r = dfive * 10000 + mlate;
        else return 0;
        return r + (r % 1000000) * 2 / 3;
    endfunction

    function automatic logic [1:0] hemi(logic [7:0] p, logic [7:0] m);
        if (flen != 1) return nggp_pkg::HEMI_NONE;
        if (fbyte == p) return nggp_pkg::HEMI_POS;
        if (fbyte == m) return nggp_pkg::HEMI_NEG;
        return nggp_pkg::HEMI_NONE;
    endfunction

    function automatic logic [31:0] signed_val(logic [31:0] v, logic [1:0] h);
        if (h == nggp_pkg::HEMI_POS) return v;
        if (h == nggp_pkg::HEMI_NEG) return 32'd0 - v;
        return 0;
    endfunction

    task automatic close_field(logic [31:0] k);
        logic [31:0] c;
        if (lkind == nggp_pkg::KIND_GGA) begin
            case (k)
                1: pend[nggp_pkg::SLOT_LAT] = deg_val();
                2: psign[0] = hemi(nggp_pkg::CH_N, nggp_pkg::CH_S);
                3: pend[nggp_pkg::SLOT_LON] = deg_val();
                4: psign[1] = hemi(nggp_pkg::CH_E, nggp_pkg::CH_W);
                7: pend[nggp_pkg::SLOT_ACC] = num_val();
                8: pend[nggp_pkg::SLOT_ALT] = num_val();
                default: ;
            endcase
        end else if (lkind == nggp_pkg::KIND_VTG) begin
            if (k == 0) begin
                c = num_val() / 100;
                if (c > 180) c = c - 360;
                pend[nggp_pkg::SLOT_CRS] = c;
            end else if (k == 6) begin
                c = num_val() * 100;
                pend[nggp_pkg::SLOT_SPD] = c / 36;
            end
        end
    endtask

    task automatic field_char(logic [7:0] ch);
        logic [31:0] p;
        logic [31:0] d;
        p = flen;
        d = {24'd0, ch} - 32'd48;
        if (p == 0) fbyte = ch;
        if (ch == nggp_pkg::CH_POINT) begin
            pnt = 1'b1; decs = 0;
        end else begin
            acc = acc * 10 + d;
            if (pnt && decs < 15) decs++;
        end
        if (p < 4) dwhole = dwhole * 10 + d;
        if (p == 4) dfive = dwhole * 10 + d;
        if (p >= 5 && p <= 8) mfrac = mfrac * 10 + d;
        if (p >= 6 && p <= 9) mlate = mlate * 10 + d;
        if (flen < 255) flen++;
    endtask

    task automatic predict_byte(logic [7:0] ch, logic eol);
        nggp_pkg::t_res  r;
        nggp_pkg::t_kind k;
        if (llen < nggp_pkg::LINE_MAX) begin
            llen++;
            if (lkind == nggp_pkg::KIND_NONE) begin
                win = {win[31:0], ch};
                if (llen >= 5) begin
                    if (win == nggp_pkg::TAG_GGA) lkind = nggp_pkg::KIND_GGA;
                    else if (win == nggp_pkg::TAG_VTG) lkind = nggp_pkg::KIND_VTG;
                end
            end else if (ch == nggp_pkg::CH_COMMA) begin
                if (commas >= 1) close_field(commas - 1);
                if (commas < 15) commas++;
                clear_field();
            end else if (commas >= 1) begin
                field_char(ch);
            end
        end
        if (!eol) return;
        k = nggp_pkg::KIND_NONE;
        if (lkind == nggp_pkg::KIND_GGA && commas >= 14) begin
            stored[nggp_pkg::SLOT_LAT] = signed_val(pend[nggp_pkg::SLOT_LAT], psign[0]);
            stored[nggp_pkg::SLOT_LON] = signed_val(pend[nggp_pkg::SLOT_LON], psign[1]);
            stored[nggp_pkg::SLOT_ACC] = pend[nggp_pkg::SLOT_ACC];
            stored[nggp_pkg::SLOT_ALT] = pend[nggp_pkg::SLOT_ALT];
            k = nggp_pkg::KIND_GGA;
        end else if (lkind == nggp_pkg::KIND_VTG && commas >= 9) begin
            stored[nggp_pkg::SLOT_CRS] = pend[nggp_pkg::SLOT_CRS];
            stored[nggp_pkg::SLOT_SPD] = pend[nggp_pkg::SLOT_SPD];
            k = nggp_pkg::KIND_VTG;
        end
        clear_line();
        r.kind = k;
        r.lat = stored[nggp_pkg::SLOT_LAT][30:0];
        r.lon = stored[nggp_pkg::SLOT_LON][30:0];
        r.acc = stored[nggp_pkg::SLOT_ACC];
        r.alt = stored[nggp_pkg::SLOT_ALT];
        r.course = stored[nggp_pkg::SLOT_CRS];
        r.speed = stored[nggp_pkg::SLOT_SPD][26:0];
        results_q.push_back(r);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // send one byte: burst/gap idling, then request held until accepted
    task automatic send_byte(logic [7:0] ch, logic eol);
        if (send_burst == 0) begin
            send_burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        send_burst--;
        i_push <= 1'b1;
        i_rx_byte <= ch;
        i_end_of_line <= eol;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_byte(ch, eol);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // result checker
    always @(posedge i_clk) begin
        nggp_pkg::t_res e;
        if (i_rst_n && i_pop && !o_empty) begin
            if (results_q.size() == 0) begin
                report("unexpected result", {30'd0, o_sentence_kind}, 32'd0);
            end else begin
                e = results_q.pop_front();
                if (o_sentence_kind !== e.kind)
                    report("kind", {30'd0, o_sentence_kind}, {30'd0, e.kind});
                if (o_latitude_udeg !== e.lat)
                    report("lat", {1'b0, o_latitude_udeg}, {1'b0, e.lat});
                if (o_longitude_udeg !== e.lon)
                    report("lon", {1'b0, o_longitude_udeg}, {1'b0, e.lon});
                if (o_fix_accuracy !== e.acc) report("acc", o_fix_accuracy, e.acc);
                if (o_altitude_cm !== e.alt) report("alt", o_altitude_cm, e.alt);
                if (o_course_deg !== e.course) report("course", o_course_deg, e.course);
                if (o_speed_value !== e.speed)
                    report("speed", {5'd0, o_speed_value}, {5'd0, e.speed});
            end
        end
    end

    // reader stall pattern: phases of steady reading, of random reading and of heavy stalling
    always @(negedge i_clk) begin
        if (!i_rst_n) i_pop <= 1'b0;
        else if ((cycles / 500) % 3 == 0) i_pop <= 1'b1;
        else if ((cycles / 500) % 3 == 1) i_pop <= ($urandom_range(0, 1) == 0);
        else i_pop <= ($urandom_range(0, 9) == 0);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic string digits(int n);
        string s;
        s = "";
        repeat (n) s = {s, string'(8'(8'h30 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string num_field();
        string s;
        int m;
        m = $urandom_range(0, 9);
        s = digits($urandom_range(0, 5));
        if (m < 6) s = {s, ".", digits($urandom_range(0, 5))};
        else if (m == 6) s = {s, ".", digits(1), ".", digits(2)};
        if ($urandom_range(0, 15) == 0) s = {s, string'(8'($urandom_range(33, 126)))};
        return s;
    endfunction

    function automatic string deg_field(int w);
        string s;
        if ($urandom_range(0, 7) == 0) return digits($urandom_range(0, 12));
        s = {digits(w), ".", digits(4)};
        if ($urandom_range(0, 15) == 0) s[w] = "7";
        return s;
    endfunction

    function automatic string hemi_field(string a, string b);
        case ($urandom_range(0, 7))
            0: return "";
            1: return {a, a};
            2: return string'(8'($urandom_range(0, 255)));
            default: return ($urandom_range(0, 1) != 0) ? a : b;
        endcase
    endfunction

    function automatic string gga_line(int n_commas);
        string f [15];
        string s;
        f[0] = digits(6);
        f[1] = deg_field(4); f[2] = hemi_field("N", "S");
        f[3] = deg_field(5); f[4] = hemi_field("E", "W");
        f[5] = digits(1); f[6] = digits(2);
        f[7] = num_field(); f[8] = num_field();
        f[9] = "M"; f[10] = num_field(); f[11] = "M"; f[12] = ""; f[13] = "";
        f[14] = "*47";
        s = ($urandom_range(0, 3) == 0) ? "$xxGPGGA" : "$GPGGA";
        for (int i = 0; i < 15; i++) begin
            if (i < n_commas) s = {s, ","};
            s = {s, f[i]};
        end
        return s;
    endfunction

    function automatic string vtg_line(int n_commas);
        string f [10];
        string s;
        f[0] = num_field(); f[1] = "T"; f[2] = ""; f[3] = "M";
        f[4] = num_field(); f[5] = "N"; f[6] = num_field(); f[7] = "K";
        f[8] = "A"; f[9] = "*2F";
        s = "$GPVTG";
        for (int i = 0; i < 10; i++) begin
            if (i < n_commas) s = {s, ","};
            s = {s, f[i]};
        end
        return s;
    endfunction

    task automatic send_random_bytes(int n);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    task automatic test_directed();
        send_line("$GPGGA,123519,4807.0381,N,01131.0001,E,1,08,0.9,545.4,M,46.9,M,,*47");
        send_line("$GPGGA,0,9000.0000,S,18000.0000,W,1,08,9,12.345,M,,M,,");
        send_line("$GPGGA,0,5959.9999,X,17959.9999,EE,1,08,5,.,M,,M,,");
        send_line("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K*48");
        send_line("$GPVTG,359.99,T,,M,,N,9999999.99,K,A");
        send_line("$GPVTG,180.00,T,,M,,N,4294967,K,A");
        send_line("$GPVTG,5,T,,M,,N,1..2.3,K,A");
        send_line("$GPVTG,054.7,T,034.4");
        send_line("$GPGGAGPVTG,1,2,3,4,5,6,7,8,9,10,11,12,13,14");
        send_line("garbage with no tag");
        send_line("$GPGGA,0,48A7.0381,N,011Z1.0001,W,1,08,0.9,5\xff.4,M,,M,,");
        send_line({"$GPVTG,1,2,3,4,5,6,7,8,", digits(60), ",,,"});
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_random();
        int m;
        while (bytes_sent < 1450) begin
            m = $urandom_range(0, 9);
            if (m < 4) send_line(gga_line(($urandom_range(0, 5) == 0) ?
                                          $urandom_range(0, 15) : 15));
            else if (m < 8) send_line(vtg_line(($urandom_range(0, 5) == 0) ?
                                               $urandom_range(0, 10) : 10));
            else send_random_bytes($urandom_range(1, 20));
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_push = 1'b0; i_rx_byte = 8'd0; i_end_of_line = 1'b0;
        i_pop = 1'b0;
        clear_line();
        for (int i = 0; i < 6; i++) begin pend[i] = 0; stored[i] = 0; end
        psign[0] = nggp_pkg::HEMI_NONE; psign[1] = nggp_pkg::HEMI_NONE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        i_push <= 1'b0;
        while (results_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && results_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
